@@ rtl/pss_pkg.sv @@
// Shared constants, types and table ROMs for the Phong specular shader.
// Depends on nothing; the log2/exp2 tables are built by elaboration-time functions.
`default_nettype none

package pss_pkg;

  localparam int FRAC_BITS       = 12;
  localparam int POW_TABLE_DEPTH = 256;
  localparam int TAB_IDX_W       = $clog2(POW_TABLE_DEPTH);
  localparam int LANE_W          = 16;
  localparam int X_W             = FRAC_BITS + 4;
  localparam logic [X_W-1:0] XMAX = {X_W{1'b1}};
  localparam logic [X_W-1:0] ONE_FX = X_W'(1) << FRAC_BITS;
  localparam int SH_BASE         = 30 - FRAC_BITS;
  localparam logic [15:0] EXP_ONE = 16'd256;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_SPEC_EXPONENT = 2'd0,
    REG_SPEC_GAIN     = 2'd1,
    REG_METALLIC_MODE = 2'd2
  } cfg_reg_t;

  // Colour payload carried alongside the geometry math
  typedef struct packed {
    logic [47:0] light;
    logic [47:0] surf;
    logic [47:0] accum;
  } pay_t;

  // One square-root digit step result
  typedef struct packed {
    logic [19:0] rem;
    logic [15:0] root;
  } sq_step_t;

  typedef logic [15:0] log_tab_t [POW_TABLE_DEPTH];
  typedef logic [30:0] exp_tab_t [POW_TABLE_DEPTH];

  // Floor integer square root, used only while building tables
  function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] bm;
    v   = v_in;
    res = '0;
    bm  = 64'h1 << 62;
    for (int k = 0; k < 32; k++) begin
      if (bm > v) bm = bm >> 2;
    end
    for (int k = 0; k < 32; k++) begin
      if (bm != 0) begin
        if (v >= res + bm) begin
          v   = v - (res + bm);
          res = (res >> 1) + bm;
        end else begin
          res = res >> 1;
        end
        bm = bm >> 2;
      end
    end
    return res;
  endfunction

  // log2(1 + i/D) in Q.16 by repeated squaring
  function automatic log_tab_t build_log();
    log_tab_t   tab;
    logic [63:0] y;
    logic [63:0] acc;
    for (int i = 0; i < POW_TABLE_DEPTH; i++) begin
      y   = ((64'(POW_TABLE_DEPTH) + 64'(i)) << 30) / POW_TABLE_DEPTH;
      acc = '0;
      for (int k = 0; k < 16; k++) begin
        y   = (y * y) >> 30;
        acc = acc << 1;
        if (y >= (64'h1 << 31)) begin
          y   = y >> 1;
          acc = acc | 64'h1;
        end
      end
      tab[i] = acc[15:0];
    end
    return tab;
  endfunction

  // 2^(j/D) in Q1.30 from products of repeated square roots of two
  function automatic exp_tab_t build_exp();
    exp_tab_t    tab;
    logic [63:0] roots [17];
    logic [63:0] fq;
    logic [63:0] e;
    roots[0] = 64'h1 << 31;
    for (int k = 1; k <= 16; k++) begin
      roots[k] = isqrt64(roots[k-1] << 30);
    end
    for (int i = 0; i < POW_TABLE_DEPTH; i++) begin
      fq = (64'(i) << 16) / POW_TABLE_DEPTH;
      e  = 64'h1 << 30;
      for (int k = 1; k <= 16; k++) begin
        if (((fq >> (16 - k)) & 64'h1) != 0) e = (e * roots[k]) >> 30;
      end
      tab[i] = e[30:0];
    end
    return tab;
  endfunction

  localparam log_tab_t LOG_TAB = build_log();
  localparam exp_tab_t EXP_TAB = build_exp();

endpackage

`default_nettype wire

@@ rtl/phong_specular_shade.sv @@
// Phong specular shader top level: reflect, cosine, power, gain, tint, accumulate.
// Depends on pss_pkg for constants, payload types and the log2/exp2 ROMs.
// Throughput one request per cycle while out_ready does not stall the pipeline.
// Square root and divide run as 8-stage digit pipelines, two digits per stage.
// Ready propagates back combinationally through every stage, so bubbles are squeezed out on a stall.
// Reset clears all stage valid bits and loads the configuration defaults.
`default_nettype none

module phong_specular_shade (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [47:0] in_eye_dir,
  input  wire logic [47:0] in_surface_normal,
  input  wire logic [47:0] in_light_dir,
  input  wire logic [47:0] in_light_rgb,
  input  wire logic [47:0] in_surface_rgb,
  input  wire logic [47:0] in_accum_rgb,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [47:0]      out_result_rgb,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  localparam int NST      = 30;
  localparam int ST_SQ0   = 6;
  localparam int ST_DIVI  = 14;
  localparam int ST_DIV0  = 15;
  localparam int ST_LZ    = 23;
  localparam int ST_LOG   = 24;
  localparam int ST_TMUL  = 25;
  localparam int ST_EXP   = 26;
  localparam int ST_GAIN  = 27;
  localparam int ST_TINT  = 28;
  localparam int ST_OUT   = 29;
  localparam int XW       = pss_pkg::X_W;

  // Configuration registers
  logic [15:0] spec_exp_r;
  logic [15:0] spec_gain_r;
  logic        metallic_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spec_exp_r  <= 16'd10240;
      spec_gain_r <= 16'd0;
      metallic_r  <= 1'b0;
    end else if (cfg_valid) begin
      case (pss_pkg::cfg_reg_t'(cfg_index))
        pss_pkg::REG_SPEC_EXPONENT: spec_exp_r  <= cfg_data;
        pss_pkg::REG_SPEC_GAIN:     spec_gain_r <= cfg_data;
        pss_pkg::REG_METALLIC_MODE: metallic_r  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Stage valids, enables and carried colours
  logic [NST-1:0]  v_r;
  logic [NST-1:0]  en;
  pss_pkg::pay_t   pay_r [NST];

  always_comb begin
    en[NST-1] = !v_r[NST-1] || out_ready;
    for (int k = NST - 2; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v_r[NST-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= in_valid;
      for (int k = 1; k < NST; k++) begin
        if (en[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      pay_r[0] <= '{light: in_light_rgb, surf: in_surface_rgb, accum: in_accum_rgb};
    end
    for (int k = 1; k < NST; k++) begin
      if (en[k]) pay_r[k] <= pay_r[k-1];
    end
  end

  // Stage 0: E.N terms and squares of L
  logic signed [15:0] e0_r   [3];
  logic signed [15:0] n0_r   [3];
  logic signed [15:0] l0_r   [3];
  logic signed [31:0] en0_r  [3];
  logic        [30:0] ll0_r  [3];
  logic signed [15:0] in_e   [3];
  logic signed [15:0] in_n   [3];
  logic signed [15:0] in_l   [3];
  logic signed [31:0] ll_w   [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      in_e[k] = $signed(in_eye_dir[16*k +: 16]);
      in_n[k] = $signed(in_surface_normal[16*k +: 16]);
      in_l[k] = $signed(in_light_dir[16*k +: 16]);
      ll_w[k] = in_l[k] * in_l[k];
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      for (int k = 0; k < 3; k++) begin
        e0_r[k]  <= in_e[k];
        n0_r[k]  <= in_n[k];
        l0_r[k]  <= in_l[k];
        en0_r[k] <= in_e[k] * in_n[k];
        ll0_r[k] <= ll_w[k][30:0];
      end
    end
  end

  // Stage 1: |E.N|, normal flipped to face the eye, |L|^2
  logic signed [15:0] e1_r  [3];
  logic signed [15:0] l1_r  [3];
  logic signed [16:0] nn1_r [3];
  logic        [31:0] cab1_r;
  logic        [31:0] sq1_r;
  logic signed [33:0] c_w;

  assign c_w = 34'(en0_r[0]) + 34'(en0_r[1]) + 34'(en0_r[2]);

  always_ff @(posedge clk) begin
    if (en[1]) begin
      cab1_r <= c_w[33] ? 32'(-c_w) : c_w[31:0];
      sq1_r  <= 32'(ll0_r[0]) + 32'(ll0_r[1]) + 32'(ll0_r[2]);
      for (int k = 0; k < 3; k++) begin
        e1_r[k]  <= e0_r[k];
        l1_r[k]  <= l0_r[k];
        nn1_r[k] <= c_w[33] ? 17'(n0_r[k]) : -17'(n0_r[k]);
      end
    end
  end

  // Stage 2: |E.N| times flipped normal
  logic signed [15:0] e2_r [3];
  logic signed [15:0] l2_r [3];
  logic signed [49:0] p2_r [3];
  logic        [31:0] sq2_r;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      sq2_r <= sq1_r;
      for (int k = 0; k < 3; k++) begin
        e2_r[k] <= e1_r[k];
        l2_r[k] <= l1_r[k];
        p2_r[k] <= $signed({1'b0, cab1_r}) * nn1_r[k];
      end
    end
  end

  // Stage 3: reflected lane, floored back to the input scale
  logic signed [27:0] r3_r [3];
  logic signed [15:0] l3_r [3];
  logic        [31:0] sq3_r;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      sq3_r <= sq2_r;
      for (int k = 0; k < 3; k++) begin
        l3_r[k] <= l2_r[k];
        r3_r[k] <= 28'(e2_r[k]) + 28'(p2_r[k] >>> (2 * pss_pkg::FRAC_BITS - 1));
      end
    end
  end

  // Stage 4: R.L terms
  logic signed [43:0] rl4_r [3];
  logic        [31:0] sq4_r;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      sq4_r <= sq3_r;
      for (int k = 0; k < 3; k++) begin
        rl4_r[k] <= r3_r[k] * l3_r[k];
      end
    end
  end

  // Stage 5: R.L sum
  logic signed [45:0] d5_r;
  logic        [31:0] sq5_r;

  always_ff @(posedge clk) begin
    if (en[5]) begin
      sq5_r <= sq4_r;
      d5_r  <= 46'(rl4_r[0]) + 46'(rl4_r[1]) + 46'(rl4_r[2]);
    end
  end

  // Stages 6..13: |L| by digit-by-digit square root, two digits per stage
  function automatic pss_pkg::sq_step_t sqrt_step(input logic [19:0] rem,
                                                  input logic [15:0] root,
                                                  input logic [1:0]  pair);
    logic [19:0] r4;
    logic [19:0] trial;
    pss_pkg::sq_step_t o;
    r4    = {rem[17:0], pair};
    trial = {2'b00, root, 2'b01};
    if (r4 >= trial) begin
      o.rem  = r4 - trial;
      o.root = {root[14:0], 1'b1};
    end else begin
      o.rem  = r4;
      o.root = {root[14:0], 1'b0};
    end
    return o;
  endfunction

  logic        [31:0] sqv_r  [8];
  logic        [19:0] srem_r [8];
  logic        [15:0] sroot_r[8];
  logic signed [45:0] sd_r   [8];

  for (genvar j = 0; j < 8; j++) begin : g_sqrt
    logic        [31:0] v_in;
    logic        [19:0] rem_in;
    logic        [15:0] root_in;
    logic signed [45:0] d_in;
    pss_pkg::sq_step_t  s_a;
    pss_pkg::sq_step_t  s_b;

    if (j == 0) begin : g_first
      assign v_in    = sq5_r;
      assign rem_in  = '0;
      assign root_in = '0;
      assign d_in    = d5_r;
    end else begin : g_next
      assign v_in    = sqv_r[j-1];
      assign rem_in  = srem_r[j-1];
      assign root_in = sroot_r[j-1];
      assign d_in    = sd_r[j-1];
    end

    assign s_a = sqrt_step(rem_in, root_in, v_in[31:30]);
    assign s_b = sqrt_step(s_a.rem, s_a.root, v_in[29:28]);

    always_ff @(posedge clk) begin
      if (en[ST_SQ0 + j]) begin
        sqv_r[j]   <= {v_in[27:0], 4'b0000};
        srem_r[j]  <= s_b.rem;
        sroot_r[j] <= s_b.root;
        sd_r[j]    <= d_in;
      end
    end
  end

  // Stage 14: zero and saturation checks ahead of the divide
  logic [31:0] num14_r;
  logic [15:0] den14_r;
  logic        xz14_r;
  logic        xs14_r;
  logic        xz_w;

  assign xz_w = (sroot_r[7] == '0) || (sd_r[7] <= 0);

  always_ff @(posedge clk) begin
    if (en[ST_DIVI]) begin
      num14_r <= sd_r[7][31:0];
      den14_r <= sroot_r[7];
      xz14_r  <= xz_w;
      xs14_r  <= !xz_w && (sd_r[7] >= $signed({14'b0, sroot_r[7], 16'b0}));
    end
  end

  // Stages 15..22: restoring divide R.L / |L|, two quotient bits per stage
  logic [31:0] drem_r [8];
  logic [15:0] dq_r   [8];
  logic [15:0] dden_r [8];
  logic        dz_r   [8];
  logic        ds_r   [8];

  for (genvar j = 0; j < 8; j++) begin : g_div
    localparam int IA = 15 - 2 * j;
    localparam int IB = 14 - 2 * j;
    logic [31:0] rem_in;
    logic [15:0] q_in;
    logic [15:0] den_in;
    logic        z_in;
    logic        s_in;
    logic [31:0] sub_a;
    logic [31:0] sub_b;
    logic [31:0] rem_a;
    logic [31:0] rem_b;
    logic [15:0] q_a;
    logic [15:0] q_b;

    if (j == 0) begin : g_first
      assign rem_in = num14_r;
      assign q_in   = '0;
      assign den_in = den14_r;
      assign z_in   = xz14_r;
      assign s_in   = xs14_r;
    end else begin : g_next
      assign rem_in = drem_r[j-1];
      assign q_in   = dq_r[j-1];
      assign den_in = dden_r[j-1];
      assign z_in   = dz_r[j-1];
      assign s_in   = ds_r[j-1];
    end

    always_comb begin
      sub_a = 32'(den_in) << IA;
      rem_a = rem_in;
      q_a   = q_in;
      if (rem_in >= sub_a) begin
        rem_a    = rem_in - sub_a;
        q_a[IA]  = 1'b1;
      end
      sub_b = 32'(den_in) << IB;
      rem_b = rem_a;
      q_b   = q_a;
      if (rem_a >= sub_b) begin
        rem_b    = rem_a - sub_b;
        q_b[IB]  = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (en[ST_DIV0 + j]) begin
        drem_r[j] <= rem_b;
        dq_r[j]   <= q_b;
        dden_r[j] <= den_in;
        dz_r[j]   <= z_in;
        ds_r[j]   <= s_in;
      end
    end
  end

  // Stage 23: cosine select and leading-one position
  logic [XW-1:0] x_w;
  logic [3:0]    m_w;
  logic [XW-1:0] x23_r;
  logic [3:0]    m23_r;

  always_comb begin
    if (dz_r[7]) x_w = '0;
    else if (ds_r[7]) x_w = pss_pkg::XMAX;
    else x_w = dq_r[7];
    m_w = '0;
    for (int b = 0; b < XW; b++) begin
      if (x_w[b]) m_w = 4'(b);
    end
  end

  always_ff @(posedge clk) begin
    if (en[ST_LZ]) begin
      x23_r <= x_w;
      m23_r <= m_w;
    end
  end

  // Stage 24: log2 of the cosine, Q.16
  logic [XW-1:0]      xn_w;
  logic signed [5:0]  me_w;
  logic signed [21:0] l24_r;
  logic [XW-1:0]      x24_r;
  logic               xz24_r;

  assign xn_w = x23_r << (4'(XW - 1) - m23_r);
  assign me_w = $signed({2'b00, m23_r}) - 6'(pss_pkg::FRAC_BITS);

  always_ff @(posedge clk) begin
    if (en[ST_LOG]) begin
      l24_r  <= {me_w, pss_pkg::LOG_TAB[xn_w[XW-2 -: pss_pkg::TAB_IDX_W]]};
      x24_r  <= x23_r;
      xz24_r <= (x23_r == '0);
    end
  end

  // Stage 25: times the exponent
  logic signed [38:0] tp_w;
  logic signed [30:0] t25_r;
  logic [XW-1:0]      x25_r;
  logic               xz25_r;

  assign tp_w = l24_r * $signed({1'b0, spec_exp_r});

  always_ff @(posedge clk) begin
    if (en[ST_TMUL]) begin
      t25_r  <= tp_w[38:8];
      x25_r  <= x24_r;
      xz25_r <= xz24_r;
    end
  end

  // Stage 26: exp2 and the special exponents
  logic signed [14:0] n_w;
  logic signed [14:0] sh_w;
  logic [30:0]        ev_w;
  logic [XW-1:0]      pw_w;
  logic [XW-1:0]      y_w;
  logic [XW-1:0]      y26_r;

  assign n_w  = t25_r[30:16];
  assign sh_w = 15'(pss_pkg::SH_BASE) - n_w;
  assign ev_w = pss_pkg::EXP_TAB[t25_r[15 -: pss_pkg::TAB_IDX_W]];

  always_comb begin
    if (n_w >= 15'sd4) pw_w = pss_pkg::XMAX;
    else if (sh_w > 15'sd31) pw_w = '0;
    else pw_w = XW'(ev_w >> sh_w[4:0]);
    if (spec_exp_r == pss_pkg::EXP_ONE) y_w = x25_r;
    else if (spec_exp_r == '0) y_w = pss_pkg::ONE_FX;
    else if (xz25_r) y_w = '0;
    else y_w = pw_w;
  end

  always_ff @(posedge clk) begin
    if (en[ST_EXP]) y26_r <= y_w;
  end

  // Stage 27: specular gain
  logic [31:0] ig_w;
  logic [17:0] int27_r;

  assign ig_w = y26_r * spec_gain_r;

  always_ff @(posedge clk) begin
    if (en[ST_GAIN]) int27_r <= ig_w[31:14];
  end

  // Stage 28: tint per channel
  logic [47:0] tint_w;
  logic [33:0] hp_w  [3];
  logic [21:0] hl28_r[3];

  assign tint_w = metallic_r ? pay_r[ST_TINT-1].surf : pay_r[ST_TINT-1].light;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      hp_w[k] = int27_r * tint_w[16*k +: 16];
    end
  end

  always_ff @(posedge clk) begin
    if (en[ST_TINT]) begin
      for (int k = 0; k < 3; k++) begin
        hl28_r[k] <= hp_w[k][33:pss_pkg::FRAC_BITS];
      end
    end
  end

  // Stage 29: accumulate with per-channel saturation
  logic [22:0] s_w [3];
  logic [47:0] res_w;
  logic [47:0] out_r;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      s_w[k] = 23'(pay_r[ST_OUT-1].accum[16*k +: 16]) + 23'(hl28_r[k]);
      res_w[16*k +: 16] = (s_w[k] > 23'hFFFF) ? 16'hFFFF : s_w[k][15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[ST_OUT]) out_r <= res_w;
  end

  assign out_result_rgb = out_r;

endmodule

`default_nettype wire
